FILE: src/eab_pkg.sv
// Package for the block ADPCM decoder: payload structs, the front-to-back command,
// CSR indexes, arithmetic constants and the predictor coefficient table.
// Depends on nothing; every other file in src imports it.
package eab_pkg;

   localparam int EAB_QUEUE_DEPTH = 2;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEREO_MODE = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLIP_ENABLE = 1'd1;

   localparam int COEF_WIDTH = 10;
   localparam int PROD_WIDTH = 16 + COEF_WIDTH;
   localparam int NIBBLE_POS = 28;
   localparam int OUT_SHIFT  = 8;

   localparam logic [4:0]         SHIFT_BIAS = 5'd8;
   localparam logic [4:0]         C2_OFFSET  = 5'd4;
   localparam logic signed [31:0] ROUND_BIAS = 32'sh0000_0080;
   localparam logic signed [31:0] CLIP_MAX   = 32'sd32767;
   localparam logic signed [31:0] CLIP_MIN   = -32'sd32768;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       block_start;
      logic       stream_start;
   } eab_req_type;

   typedef struct packed {
      logic signed [15:0] sample_a;
      logic signed [15:0] sample_b;
   } eab_rsp_type;

   // One unit of work for the decode engine. A command with clear set and
   // has_data low only wipes the sample history.
   typedef struct packed {
      logic       clear;
      logic       has_data;
      logic       stereo;
      logic [7:0] data_byte;
      logic [3:0] idx_left;
      logic [3:0] idx_right;
      logic [4:0] shift_left;
      logic [4:0] shift_right;
   } eab_cmd_type;

   function automatic logic signed [COEF_WIDTH-1:0] coef_lookup(input logic [4:0] pos);
      logic signed [COEF_WIDTH-1:0] c;
      case (pos)
         5'd0:    c = 10'sd0;
         5'd1:    c = 10'sd240;
         5'd2:    c = 10'sd460;
         5'd3:    c = 10'sd392;
         5'd4:    c = 10'sd0;
         5'd5:    c = 10'sd0;
         5'd6:    c = -10'sd208;
         5'd7:    c = -10'sd220;
         5'd8:    c = 10'sd0;
         5'd9:    c = 10'sd1;
         5'd10:   c = 10'sd3;
         5'd11:   c = 10'sd4;
         5'd12:   c = 10'sd7;
         5'd13:   c = 10'sd8;
         5'd14:   c = 10'sd10;
         5'd15:   c = 10'sd11;
         5'd16:   c = 10'sd0;
         5'd17:   c = -10'sd1;
         5'd18:   c = -10'sd3;
         5'd19:   c = -10'sd4;
         default: c = 10'sd0;
      endcase
      return c;
   endfunction

endpackage

FILE: src/ea_adpcm_block_decoder.sv
// Top level of the block ADPCM decoder: CSRs, front end, command queue, decode engine.
// Depends on eab_pkg, eab_front, eab_cmd_queue and eab_back.
//
// Usage:
//   Request side is a queue write port: a byte is taken at a clock edge with
//   req_push high and req_full low. The first header byte of a block carries
//   block_start; stream_start additionally clears the sample history.
//   Response side is a queue read port: while rsp_empty is low, rsp_payload
//   holds the oldest pair of samples, taken at an edge with rsp_pop high.
//   Header bytes give no response; each data byte gives one pair of samples.
//   Header bytes update the block fields in the front end. A data byte holds the
//   decode engine while it fetches the command and then makes one pass of the
//   shared multiply-add unit per sample, so the engine takes no new command
//   until the pair of the last data byte is finished.
//   If the receiver stalls, the finished pair waits in the output register,
//   one more byte can be decoded up to its second pass, and the command queue
//   absorbs QUEUE_DEPTH further commands before req_full rises.
//   CSRs (stereo_mode, clip_enable) are written through csr_write, csr_index
//   and csr_data while the block is idle.
//   Synchronous reset empties the queue and output, sets shifts to eight and
//   zeroes indices and history; stereo_mode resets to 0, clip_enable to 1.
module ea_adpcm_block_decoder
   import eab_pkg::*;
#(
   parameter int QUEUE_DEPTH = EAB_QUEUE_DEPTH
)(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  eab_req_type                req_payload,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output eab_rsp_type                rsp_payload,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   logic        stereo_mode_ff, stereo_mode_in;
   logic        clip_enable_ff, clip_enable_in;
   logic        cmd_push;
   logic        cmd_pop;
   logic        cmd_full;
   logic        cmd_empty;
   eab_cmd_type front_cmd;
   eab_cmd_type queue_cmd;

   always_comb begin
      stereo_mode_in = stereo_mode_ff;
      clip_enable_in = clip_enable_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_STEREO_MODE: stereo_mode_in = csr_data[0];
            CSR_CLIP_ENABLE: clip_enable_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_mode_ff <= 1'b0;
         clip_enable_ff <= 1'b1;
      end else begin
         stereo_mode_ff <= stereo_mode_in;
         clip_enable_ff <= clip_enable_in;
      end
   end

   assign req_full = cmd_full;

   eab_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_payload (req_payload),
      .stereo_mode (stereo_mode_ff),
      .queue_full  (cmd_full),
      .cmd_push    (cmd_push),
      .cmd         (front_cmd)
   );

   eab_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (front_cmd),
      .pop      (cmd_pop),
      .pop_cmd  (queue_cmd),
      .full     (cmd_full),
      .empty    (cmd_empty)
   );

   eab_back u_back (
      .clock       (clock),
      .reset       (reset),
      .clip_enable (clip_enable_ff),
      .cmd         (queue_cmd),
      .cmd_empty   (cmd_empty),
      .cmd_pop     (cmd_pop),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_payload (rsp_payload)
   );

   // The engine never pops a command that is not there.
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("decode engine popped an empty command queue");

   // A header byte without stream_start must not reach the engine.
   a_header_no_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && req_payload.block_start && !req_payload.stream_start)
      |-> !cmd_push)
      else $error("plain header byte produced a command");

   // A waiting response is not dropped while the receiver stalls.
   a_rsp_kept: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("pending response lost while stalled");

endmodule

FILE: src/eab_front.sv
// Front end: accepts request bytes, tracks block headers (predictor indices and shifts)
// and turns data bytes and history clears into commands. Depends on eab_pkg.
module eab_front
   import eab_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  eab_req_type req_payload,
   input  logic        stereo_mode,
   input  logic        queue_full,
   output logic        cmd_push,
   output eab_cmd_type cmd
);

   logic [3:0] idx_left_ff, idx_left_in;
   logic [3:0] idx_right_ff, idx_right_in;
   logic [4:0] shift_left_ff, shift_left_in;
   logic [4:0] shift_right_ff, shift_right_in;
   logic       awaiting_ff, awaiting_in;
   logic       accept;
   logic [3:0] hi_nib;
   logic [3:0] lo_nib;

   assign accept = req_push && !queue_full;
   assign hi_nib = req_payload.data_byte[7:4];
   assign lo_nib = req_payload.data_byte[3:0];

   always_comb begin
      idx_left_in    = idx_left_ff;
      idx_right_in   = idx_right_ff;
      shift_left_in  = shift_left_ff;
      shift_right_in = shift_right_ff;
      awaiting_in    = awaiting_ff;
      cmd_push       = 1'b0;

      cmd.clear       = req_payload.stream_start;
      cmd.has_data    = 1'b0;
      cmd.stereo      = stereo_mode;
      cmd.data_byte   = req_payload.data_byte;
      cmd.idx_left    = idx_left_ff;
      cmd.idx_right   = idx_right_ff;
      cmd.shift_left  = shift_left_ff;
      cmd.shift_right = shift_right_ff;

      if (accept) begin
         if (req_payload.block_start) begin
            idx_left_in = hi_nib;
            if (stereo_mode) begin
               idx_right_in = lo_nib;
               awaiting_in  = 1'b1;
            end else begin
               shift_left_in = {1'b0, lo_nib} + SHIFT_BIAS;
               awaiting_in   = 1'b0;
            end
            cmd_push = req_payload.stream_start;
         end else if (awaiting_ff) begin
            // Second header byte of a stereo block carries both shifts.
            shift_left_in  = {1'b0, hi_nib} + SHIFT_BIAS;
            shift_right_in = {1'b0, lo_nib} + SHIFT_BIAS;
            awaiting_in    = 1'b0;
            cmd_push       = req_payload.stream_start;
         end else begin
            cmd.has_data = 1'b1;
            cmd_push     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_left_ff    <= '0;
         idx_right_ff   <= '0;
         shift_left_ff  <= SHIFT_BIAS;
         shift_right_ff <= SHIFT_BIAS;
         awaiting_ff    <= 1'b0;
      end else begin
         idx_left_ff    <= idx_left_in;
         idx_right_ff   <= idx_right_in;
         shift_left_ff  <= shift_left_in;
         shift_right_ff <= shift_right_in;
         awaiting_ff    <= awaiting_in;
      end
   end

endmodule

FILE: src/eab_cmd_queue.sv
// Small command FIFO between the front end and the decode engine.
// Depends on eab_pkg for the command type.
module eab_cmd_queue
   import eab_pkg::*;
#(
   parameter int DEPTH = EAB_QUEUE_DEPTH
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  eab_cmd_type push_cmd,
   input  logic        pop,
   output eab_cmd_type pop_cmd,
   output logic        full,
   output logic        empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   eab_cmd_type      entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: src/eab_back.sv
// Decode engine: pops commands, runs one shared predictor pass per sample and holds
// the per-channel history and the output register. Depends on eab_pkg.
module eab_back
   import eab_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        clip_enable,
   input  eab_cmd_type cmd,
   input  logic        cmd_empty,
   output logic        cmd_pop,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output eab_rsp_type rsp_payload
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PASS_A,
      ST_PASS_B
   } state_type;

   state_type          state_ff, state_in;
   eab_cmd_type        cmd_ff, cmd_in;
   logic signed [15:0] cur_l_ff, cur_l_in, prev_l_ff, prev_l_in;
   logic signed [15:0] cur_r_ff, cur_r_in, prev_r_ff, prev_r_in;
   logic signed [15:0] sample_a_ff, sample_a_in;
   logic               out_valid_ff, out_valid_in;
   eab_rsp_type        out_ff, out_in;

   // Operands of the shared predictor pass.
   logic [3:0]                   op_nib;
   logic [3:0]                   op_idx;
   logic [4:0]                   op_shift;
   logic signed [15:0]           op_cur;
   logic signed [15:0]           op_prev;
   logic signed [COEF_WIDTH-1:0] c1;
   logic signed [COEF_WIDTH-1:0] c2;
   logic signed [PROD_WIDTH-1:0] prod1;
   logic signed [PROD_WIDTH-1:0] prod2;
   logic signed [31:0]           term;
   logic signed [31:0]           sum;
   logic signed [31:0]           acc;
   logic signed [15:0]           result;
   logic                         use_right;
   logic                         out_free;

   assign use_right = (state_ff == ST_PASS_B) && cmd_ff.stereo;
   assign out_free  = !out_valid_ff || rsp_pop;

   always_comb begin
      op_nib   = (state_ff == ST_PASS_B) ? cmd_ff.data_byte[3:0] : cmd_ff.data_byte[7:4];
      op_idx   = use_right ? cmd_ff.idx_right : cmd_ff.idx_left;
      op_shift = use_right ? cmd_ff.shift_right : cmd_ff.shift_left;
      op_cur   = use_right ? cur_r_ff : cur_l_ff;
      op_prev  = use_right ? prev_r_ff : prev_l_ff;

      c1    = coef_lookup({1'b0, op_idx});
      c2    = coef_lookup({1'b0, op_idx} + C2_OFFSET);
      prod1 = PROD_WIDTH'(op_cur) * PROD_WIDTH'(c1);
      prod2 = PROD_WIDTH'(op_prev) * PROD_WIDTH'(c2);
      term  = $signed({op_nib, {NIBBLE_POS{1'b0}}}) >>> op_shift;
      sum   = term + 32'(prod1) + 32'(prod2) + ROUND_BIAS;
      acc   = sum >>> OUT_SHIFT;

      if (!clip_enable) begin
         result = acc[15:0];
      end else if (acc > CLIP_MAX) begin
         result = CLIP_MAX[15:0];
      end else if (acc < CLIP_MIN) begin
         result = CLIP_MIN[15:0];
      end else begin
         result = acc[15:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cur_l_in     = cur_l_ff;
      prev_l_in    = prev_l_ff;
      cur_r_in     = cur_r_ff;
      prev_r_in    = prev_r_ff;
      sample_a_in  = sample_a_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      cmd_pop      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               if (cmd.clear) begin
                  cur_l_in  = '0;
                  prev_l_in = '0;
                  cur_r_in  = '0;
                  prev_r_in = '0;
               end
               if (cmd.has_data) begin
                  state_in = ST_PASS_A;
               end
            end
         end
         ST_PASS_A: begin
            // The high nibble always belongs to the left (or only) channel.
            prev_l_in   = cur_l_ff;
            cur_l_in    = result;
            sample_a_in = result;
            state_in    = ST_PASS_B;
         end
         ST_PASS_B: begin
            // History is committed only together with the result, so a stall
            // leaves the operands of this pass untouched.
            if (out_free) begin
               if (cmd_ff.stereo) begin
                  prev_r_in = cur_r_ff;
                  cur_r_in  = result;
               end else begin
                  prev_l_in = cur_l_ff;
                  cur_l_in  = result;
               end
               out_in.sample_a = sample_a_ff;
               out_in.sample_b = result;
               out_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         cur_l_ff     <= '0;
         prev_l_ff    <= '0;
         cur_r_ff     <= '0;
         prev_r_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         cur_l_ff     <= cur_l_in;
         prev_l_ff    <= prev_l_in;
         cur_r_ff     <= cur_r_in;
         prev_r_ff    <= prev_r_in;
      end
      cmd_ff      <= cmd_in;
      sample_a_ff <= sample_a_in;
      out_ff      <= out_in;
   end

   assign rsp_empty   = !out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

FILE: tb/ea_adpcm_block_decoder_tb.sv
// Self-checking testbench for ea_adpcm_block_decoder: directed header, stereo and wrap cases,
// then random block streams in every mode, against a built-in sample predictor.
// Depends on eab_pkg and the decoder RTL.
module ea_adpcm_block_decoder_tb;
   import eab_pkg::*;

   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 1500;
   localparam int MAX_PRINTED    = 50;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_push    = 1'b0;
   logic                       req_full;
   eab_req_type                req_payload = '0;
   logic                       rsp_empty;
   logic                       rsp_pop     = 1'b0;
   eab_rsp_type                rsp_payload;
   logic                       csr_write   = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index   = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data    = '0;

   ea_adpcm_block_decoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: configuration, block header fields and per-channel history.
   bit                 pred_stereo;
   bit                 pred_clip;
   logic [3:0]         pred_idx_left, pred_idx_right;
   logic [4:0]         pred_shift_left, pred_shift_right;
   bit                 pred_shift_pending;
   logic signed [15:0] hist_cur [2];
   logic signed [15:0] hist_prev [2];

   int coef_table [0:19] = '{0, 240, 460, 392, 0, 0, -208, -220, 0, 1, 3, 4, 7, 8, 10, 11,
                             0, -1, -3, -4};

   eab_rsp_type expected_samples [$];

   int n_errors  = 0;
   int n_sent    = 0;
   int n_headers = 0;
   int n_pairs   = 0;

   bit sender_gaps = 1'b0;
   int burst_left  = 0;
   int stall_pct   = 0;
   int stall_left  = 0;
   int idle_cycles = 0;

   function automatic void clear_history();
      for (int ch = 0; ch < 2; ch++) begin
         hist_cur[ch]  = '0;
         hist_prev[ch] = '0;
      end
   endfunction

   function automatic void reset_predictor();
      pred_stereo        = 1'b0;
      pred_clip          = 1'b1;
      pred_idx_left      = '0;
      pred_idx_right     = '0;
      pred_shift_left    = 5'd8;
      pred_shift_right   = 5'd8;
      pred_shift_pending = 1'b0;
      clear_history();
   endfunction

   function automatic logic signed [15:0] decode_nibble(input logic [3:0] nib,
                                                        input logic [3:0] idx,
                                                        input logic [4:0] shift, input int ch);
      longint             term, acc, c1, c2;
      logic signed [15:0] s;
      c1   = coef_table[idx];
      c2   = coef_table[int'(idx) + 4];
      term = longint'($signed(nib)) <<< 28;
      term = term >>> shift;
      acc  = (term + longint'(hist_cur[ch]) * c1 + longint'(hist_prev[ch]) * c2 + 128) >>> 8;
      if (pred_clip && acc > 32767) begin
         s = 16'sh7fff;
      end else if (pred_clip && acc < -32768) begin
         s = 16'sh8000;
      end else begin
         s = acc[15:0];
      end
      hist_prev[ch] = hist_cur[ch];
      hist_cur[ch]  = s;
      return s;
   endfunction

   // Returns 1 when the byte is a data byte and fills in the sample pair it decodes to.
   function automatic bit predict_byte(input eab_req_type r, output eab_rsp_type pair);
      logic [3:0] hi, lo;
      hi   = r.data_byte[7:4];
      lo   = r.data_byte[3:0];
      pair = '0;
      if (r.stream_start) clear_history();
      if (r.block_start) begin
         pred_idx_left = hi;
         if (pred_stereo) begin
            pred_idx_right     = lo;
            pred_shift_pending = 1'b1;
         end else begin
            pred_shift_left    = 5'(lo) + 5'd8;
            pred_shift_pending = 1'b0;
         end
         return 1'b0;
      end
      if (pred_shift_pending) begin
         pred_shift_left    = 5'(hi) + 5'd8;
         pred_shift_right   = 5'(lo) + 5'd8;
         pred_shift_pending = 1'b0;
         return 1'b0;
      end
      if (pred_stereo) begin
         pair.sample_a = decode_nibble(hi, pred_idx_left, pred_shift_left, 0);
         pair.sample_b = decode_nibble(lo, pred_idx_right, pred_shift_right, 1);
      end else begin
         pair.sample_a = decode_nibble(hi, pred_idx_left, pred_shift_left, 0);
         pair.sample_b = decode_nibble(lo, pred_idx_left, pred_shift_left, 0);
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      if (n_errors < MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
      n_errors++;
   endtask

   // Sends one request, with a random gap before each new burst when gaps are enabled.
   task automatic send_byte(input eab_req_type r);
      eab_rsp_type pair;
      int          gap;
      if (sender_gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = $urandom_range(0, 6);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_push    <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_full) @(posedge clock);
      n_sent++;
      if (predict_byte(r, pair)) begin
         expected_samples.push_back(pair);
      end else begin
         n_headers++;
      end
   endtask

   task automatic send_fields(input logic [7:0] data, input logic bstart, input logic sstart);
      eab_req_type r;
      r.data_byte    = data;
      r.block_start  = bstart;
      r.stream_start = sstart;
      send_byte(r);
   endtask

   // Header bytes give no result, so after the last pair the block is given extra cycles.
   task automatic wait_idle();
      req_push   <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx, input bit val);
      wait_idle();
      csr_index <= idx;
      csr_data  <= val;
      csr_write <= 1'b1;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_STEREO_MODE) begin
         pred_stereo = val;
      end else begin
         pred_clip = val;
      end
   endtask

   always @(posedge clock) begin
      eab_rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("sample pair arrived with none expected");
            end else begin
               want = expected_samples.pop_front();
               if (rsp_payload.sample_a !== want.sample_a)
                  report_mismatch($sformatf("pair %0d sample_a got %0d expected %0d",
                                            n_pairs, rsp_payload.sample_a, want.sample_a));
               if (rsp_payload.sample_b !== want.sample_b)
                  report_mismatch($sformatf("pair %0d sample_b got %0d expected %0d",
                                            n_pairs, rsp_payload.sample_b, want.sample_b));
            end
            n_pairs++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 11);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Mono headers, data before any header, saturation and a history clear on a data byte.
   task automatic test_mono_headers();
      send_fields(8'h7f, 1'b0, 1'b0);
      send_fields(8'h80, 1'b0, 1'b0);
      send_fields(8'h2f, 1'b1, 1'b1);
      send_fields(8'h77, 1'b0, 1'b0);
      send_fields(8'h20, 1'b1, 1'b0);
      send_fields(8'h77, 1'b0, 1'b0);
      send_fields(8'h77, 1'b0, 1'b0);
      send_fields(8'h88, 1'b0, 1'b0);
      send_fields(8'h00, 1'b0, 1'b1);
      send_fields(8'hf5, 1'b1, 1'b0);
      send_fields(8'hff, 1'b0, 1'b0);
   endtask

   task automatic test_stereo_headers();
      write_csr(CSR_STEREO_MODE, 1'b1);
      send_fields(8'h3c, 1'b1, 1'b1);
      send_fields(8'h0f, 1'b0, 1'b0);
      send_fields(8'h7f, 1'b0, 1'b0);
      send_fields(8'h81, 1'b0, 1'b0);
      send_fields(8'h41, 1'b1, 1'b0);
      send_fields(8'hf0, 1'b0, 1'b1);
      send_fields(8'h8e, 1'b0, 1'b0);
   endtask

   // The byte after a stereo block start still sets both shifts once mono is selected.
   task automatic test_shift_byte_across_mode_change();
      send_fields(8'h12, 1'b1, 1'b0);
      write_csr(CSR_STEREO_MODE, 1'b0);
      send_fields(8'h35, 1'b0, 1'b0);
      send_fields(8'h7a, 1'b0, 1'b0);
   endtask

   task automatic test_wrap_without_clipping();
      write_csr(CSR_CLIP_ENABLE, 1'b0);
      send_fields(8'h20, 1'b1, 1'b0);
      send_fields(8'h77, 1'b0, 1'b0);
      send_fields(8'h77, 1'b0, 1'b0);
      send_fields(8'h77, 1'b0, 1'b0);
      send_fields(8'h88, 1'b0, 1'b0);
   endtask

   function automatic logic [3:0] extreme_nibble();
      case ($urandom_range(0, 3))
         0:       return 4'h7;
         1:       return 4'h8;
         2:       return 4'h0;
         default: return 4'hf;
      endcase
   endfunction

   // One well-formed block with random content, or now and then a single random request.
   task automatic send_random_block(inout int count);
      eab_req_type r;
      int          n_data;
      if ($urandom_range(0, 9) == 0) begin
         r = 10'($urandom_range(0, 1023));
         send_byte(r);
         count++;
         return;
      end
      send_fields(8'($urandom_range(0, 255)), 1'b1, $urandom_range(0, 3) == 0);
      count++;
      if (pred_stereo) begin
         send_fields(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 7) == 0);
         count++;
      end
      n_data = $urandom_range(1, 24);
      for (int k = 0; k < n_data; k++) begin
         if ($urandom_range(0, 3) == 0) begin
            send_fields({extreme_nibble(), extreme_nibble()}, 1'b0, 1'b0);
         end else begin
            send_fields(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 31) == 0);
         end
         count++;
      end
   endtask

   task automatic test_random_streams();
      int  quota;
      int  count;
      bit  paused;
      quota  = RANDOM_ITEMS / 4;
      paused = 1'b0;
      for (int ph = 0; ph < 4; ph++) begin
         write_csr(CSR_STEREO_MODE, ph % 2 == 1);
         write_csr(CSR_CLIP_ENABLE, ph < 2);
         sender_gaps = (ph != 0);
         case (ph)
            0:       stall_pct = 0;
            1:       stall_pct = 15;
            2:       stall_pct = 40;
            default: stall_pct = 5;
         endcase
         count = 0;
         while (count < quota) begin
            send_random_block(count);
            // Let the pipeline run dry once in the middle of a phase.
            if (ph == 2 && !paused && count >= quota / 2) begin
               wait_idle();
               paused = 1'b1;
            end
         end
      end
   endtask

   initial begin
      reset_predictor();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_mono_headers();
      test_stereo_headers();
      test_shift_byte_across_mode_change();
      test_wrap_without_clipping();
      test_random_streams();
      wait_idle();
      $display("sent %0d requests (%0d header bytes), checked %0d sample pairs",
               n_sent, n_headers, n_pairs);
      $display("mono and stereo, saturating and wrapping, shift byte across a mode change");
      if (n_errors == 0 && expected_samples.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
